>>> design/mmbp_pkg.sv
package mmbp_pkg;

    // predictor selection codes held in the mode register
    typedef enum logic [2:0] {
        MODE_NEVER     = 3'd0,
        MODE_ALWAYS    = 3'd1,
        MODE_LAST      = 3'd2,
        MODE_BIMODAL   = 3'd3,
        MODE_TWO_LEVEL = 3'd4
    } t_mode;

    localparam logic [2:0] MODE_RESET    = MODE_BIMODAL;
    localparam int         REG_ADDR_BITS = 2;
    localparam logic [REG_ADDR_BITS-1:0] REG_MODE_ADDR = 2'd0;

    // 2-bit saturating counter constants
    localparam logic [1:0] CTR_MAX      = 2'd3;
    localparam logic [1:0] CTR_MIN      = 2'd0;
    localparam logic [1:0] CTR_PHT_INIT = 2'd2;

    // pc table word: bimodal counter above the last-direction bit
    localparam int         PC_WORD_BITS = 3;
    localparam logic [PC_WORD_BITS-1:0] PC_WORD_INIT = 3'b000;

    // result of the read-modify-write step
    typedef struct packed {
        logic                    pred;
        logic                    pc_we;
        logic [PC_WORD_BITS-1:0] pc_word;
        logic                    pht_we;
        logic [1:0]              pht_ctr;
        logic                    hist_shift;
    } t_upd;

    function automatic logic [1:0] ctr_next(input logic [1:0] c, input logic taken);
        logic [1:0] r;
        if (taken) begin
            r = (c == CTR_MAX) ? CTR_MAX : c + 2'd1;
        end else begin
            r = (c == CTR_MIN) ? CTR_MIN : c - 2'd1;
        end
        return r;
    endfunction

endpackage

>>> design/multi_mode_branch_predictor.sv
// an accepted word goes through the update stage and the output register to m_axis
// throughput: one branch per cycle if m_axis is ready; forwarding covers same-entry updates
// the pc table and the pattern table are single-port-write memories with registered reads
// reset: synchronous, active low; mode returns to bimodal, history to zero
// after reset a clearing pass writes every entry of both tables with one address
// counter of max(TABLE_INDEX_BITS, HISTORY_BITS) bits; no branch is accepted meanwhile
module multi_mode_branch_predictor #(
    parameter int TABLE_INDEX_BITS = 16,
    parameter int HISTORY_BITS     = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // apb configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [mmbp_pkg::REG_ADDR_BITS-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // branch input: [31:0] branch_pc, [32] actual_taken, [39:33] zero
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,
    // prediction output: [0] predicted_taken, [7:1] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata
);
    import mmbp_pkg::*;

    localparam int CLR_BITS = (TABLE_INDEX_BITS > HISTORY_BITS) ? TABLE_INDEX_BITS
                                                                : HISTORY_BITS;

    logic [2:0]                  r_mode;
    logic                        r_clearing;
    logic [CLR_BITS-1:0]         r_clr_addr;
    logic [HISTORY_BITS-1:0]     r_hist, n_hist;
    logic                        r_s1_valid;
    logic [TABLE_INDEX_BITS-1:0] r_s1_idx;
    logic [HISTORY_BITS-1:0]     r_s1_hidx;
    logic                        r_s1_taken;
    logic                        r_pc_fwd_vld;
    logic [PC_WORD_BITS-1:0]     r_pc_fwd;
    logic                        r_pht_fwd_vld;
    logic [1:0]                  r_pht_fwd;
    logic                        r_out_valid;
    logic                        r_out_pred;

    logic                        in_acc, s1_adv;
    logic [TABLE_INDEX_BITS-1:0] in_idx;
    logic                        in_taken;
    logic [PC_WORD_BITS-1:0]     pc_rdata, pc_cur, pc_wdata;
    logic [1:0]                  pht_rdata, pht_cur, pht_wdata;
    logic                        pc_we, pht_we;
    logic [TABLE_INDEX_BITS-1:0] pc_waddr;
    logic [HISTORY_BITS-1:0]     pht_waddr;
    t_upd                        upd;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr == REG_MODE_ADDR) ? {29'd0, r_mode} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_RESET;
        end else if (psel && penable && pwrite && pready && paddr == REG_MODE_ADDR) begin
            r_mode <= pwdata[2:0];
        end
    end

    // input word fields
    assign in_idx   = s_axis_tdata[TABLE_INDEX_BITS-1:0];
    assign in_taken = s_axis_tdata[32];

    // handshakes
    assign s1_adv        = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_clearing && (!r_s1_valid || s1_adv);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == {CLR_BITS{1'b1}}) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // entry values seen by the update step, with forwarding
    assign pc_cur  = r_pc_fwd_vld  ? r_pc_fwd  : pc_rdata;
    assign pht_cur = r_pht_fwd_vld ? r_pht_fwd : pht_rdata;

    mmbp_update u_update (
        .i_mode    (r_mode),
        .i_taken   (r_s1_taken),
        .i_pc_word (pc_cur),
        .i_pht_ctr (pht_cur),
        .o_upd     (upd)
    );

    // history after the item in the update stage
    always_comb begin
        n_hist = r_hist;
        if (s1_adv && upd.hist_shift) begin
            n_hist = {r_hist[HISTORY_BITS-2:0], r_s1_taken};
        end
    end

    // table write ports: clearing pass or write-back
    always_comb begin
        if (r_clearing) begin
            pc_we     = 1'b1;
            pc_waddr  = r_clr_addr[TABLE_INDEX_BITS-1:0];
            pc_wdata  = PC_WORD_INIT;
            pht_we    = 1'b1;
            pht_waddr = r_clr_addr[HISTORY_BITS-1:0];
            pht_wdata = CTR_PHT_INIT;
        end else begin
            pc_we     = s1_adv && upd.pc_we;
            pc_waddr  = r_s1_idx;
            pc_wdata  = upd.pc_word;
            pht_we    = s1_adv && upd.pht_we;
            pht_waddr = r_s1_hidx;
            pht_wdata = upd.pht_ctr;
        end
    end

    mmbp_ram #(
        .WIDTH     (PC_WORD_BITS),
        .ADDR_BITS (TABLE_INDEX_BITS)
    ) u_pc_table (
        .i_clk   (i_clk),
        .i_we    (pc_we),
        .i_waddr (pc_waddr),
        .i_wdata (pc_wdata),
        .i_re    (in_acc),
        .i_raddr (in_idx),
        .o_rdata (pc_rdata)
    );

    mmbp_ram #(
        .WIDTH     (2),
        .ADDR_BITS (HISTORY_BITS)
    ) u_pattern_table (
        .i_clk   (i_clk),
        .i_we    (pht_we),
        .i_waddr (pht_waddr),
        .i_wdata (pht_wdata),
        .i_re    (in_acc),
        .i_raddr (n_hist),
        .o_rdata (pht_rdata)
    );

    // update stage control and history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid    <= 1'b0;
            r_pc_fwd_vld  <= 1'b0;
            r_pht_fwd_vld <= 1'b0;
            r_hist        <= '0;
        end else begin
            r_hist <= n_hist;
            if (in_acc) begin
                r_s1_valid    <= 1'b1;
                r_pc_fwd_vld  <= s1_adv && upd.pc_we && (in_idx == r_s1_idx);
                r_pht_fwd_vld <= s1_adv && upd.pht_we && (n_hist == r_s1_hidx);
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // update stage payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_idx   <= in_idx;
            r_s1_hidx  <= n_hist;
            r_s1_taken <= in_taken;
            r_pc_fwd   <= upd.pc_word;
            r_pht_fwd  <= upd.pht_ctr;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_pred <= upd.pred;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_pred};

endmodule

>>> design/mmbp_ram.sv
module mmbp_ram #(
    parameter int WIDTH     = 2,
    parameter int ADDR_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] mem [2**ADDR_BITS];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/mmbp_update.sv
module mmbp_update (
    input  logic [2:0]                  i_mode,
    input  logic                        i_taken,
    input  logic [mmbp_pkg::PC_WORD_BITS-1:0] i_pc_word,
    input  logic [1:0]                  i_pht_ctr,
    output mmbp_pkg::t_upd              o_upd
);
    import mmbp_pkg::*;

    // prediction from the old entry and its new value
    always_comb begin
        o_upd            = '0;
        o_upd.pc_word    = i_pc_word;
        o_upd.pht_ctr    = i_pht_ctr;
        case (t_mode'(i_mode))
            MODE_NEVER: begin
                o_upd.pred = 1'b0;
            end
            MODE_ALWAYS: begin
                o_upd.pred = 1'b1;
            end
            MODE_LAST: begin
                o_upd.pred       = i_pc_word[0];
                o_upd.pc_we      = 1'b1;
                o_upd.pc_word[0] = i_taken;
            end
            MODE_BIMODAL: begin
                o_upd.pred         = i_pc_word[2];
                o_upd.pc_we        = 1'b1;
                o_upd.pc_word[2:1] = ctr_next(i_pc_word[2:1], i_taken);
            end
            MODE_TWO_LEVEL: begin
                o_upd.pred       = i_pht_ctr[1];
                o_upd.pht_we     = 1'b1;
                o_upd.pht_ctr    = ctr_next(i_pht_ctr, i_taken);
                o_upd.hist_shift = 1'b1;
            end
            default: begin
                o_upd.pred = 1'b0;
            end
        endcase
    end

endmodule
